// ----- rtl/mrst_pkg.sv -----
package mrst_pkg;

    // Tree geometry
    localparam int LEAVES      = 1024;
    localparam int LEAF_W      = 11;
    localparam int VAL_W       = 30;
    localparam int NODES       = 4 * LEAVES;
    localparam int NODE_AW     = $clog2(NODES);
    localparam int STACK_DEPTH = $clog2(LEAVES);
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int SP_IW       = $clog2(STACK_DEPTH);

    // Stream widths and tdata field offsets
    localparam int TUSER_W  = 2;
    localparam int TDATA_W  = 64;
    localparam int MDATA_W  = 32;
    localparam int LEAF_LSB = 0;
    localparam int VAL_LSB  = LEAF_LSB + LEAF_W;
    localparam int LOW_LSB  = VAL_LSB + VAL_W;
    localparam int HIGH_LSB = LOW_LSB + LEAF_W;

    localparam logic [VAL_W-1:0]  MODULUS    = VAL_W'(1000000000);
    localparam logic [LEAF_W-1:0] LEAVES_MAX = LEAF_W'(LEAVES);

    typedef enum logic [TUSER_W-1:0] {
        OP_CLEAR = 2'd0,
        OP_ADD   = 2'd1,
        OP_QUERY = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    typedef struct packed {
        logic load;
        logic sweep;
        logic desc;
        logic leaf_rd;
        logic leaf_wr;
        logic sib_rd;
        logic par_wr;
        logic qry_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic sweep_last;
        logic leaf_ok;
        logic at_leaf;
        logic at_root;
        logic par_root;
        logic range_empty;
        logic walk_last;
    } t_stat;

    typedef struct packed {
        logic [NODE_AW-1:0] node;
        logic [LEAF_W-1:0]  lo;
        logic [LEAF_W-1:0]  hi;
    } t_frame;

    // Sum of two residues, folded back below the modulus
    function automatic logic [VAL_W-1:0] mod_add(input logic [VAL_W-1:0] a,
                                                 input logic [VAL_W-1:0] b);
        logic [VAL_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, MODULUS}) begin
            s = s - {1'b0, MODULUS};
        end
        return s[VAL_W-1:0];
    endfunction

endpackage

// ----- rtl/modular_range_sum_tree_top.sv -----
// Query: walks the tree nodes and sums the covered ones, then loads the output beat;
//   add: writes the leaf, then rewrites each parent up to the root; clear: sweeps all nodes.
// Throughput: one item at a time, as s_axis_tready is high only while the controller is idle.
// Reset: synchronous, active low; afterwards a clearing pass writes zero to all 4096 nodes,
//   one per cycle, with s_axis_tready low; r_leaves returns to 1024.
module modular_range_sum_tree_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [10:0] leaf_index, [40:11] add_value, [51:41] range_low, [62:52] range_high, [63] zero
    input  logic [mrst_pkg::TDATA_W-1:0]  s_axis_tdata,
    // [1:0] operation
    input  logic [mrst_pkg::TUSER_W-1:0]  s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [29:0] range_sum, [31:30] zero
    output logic [mrst_pkg::MDATA_W-1:0]  m_axis_tdata,
    input  logic                          i_cfg_wr_en,
    input  logic [mrst_pkg::LEAF_W-1:0]   i_cfg_wr_data
);

    localparam int LW = mrst_pkg::LEAF_W;
    localparam int VW = mrst_pkg::VAL_W;

    // Leaf count register and its clamped value
    logic [LW-1:0] r_leaves;
    logic [LW-1:0] leaves_eff;

    // Output beat register: holds a finished sum while the next item is taken
    logic          r_out_valid;
    logic [VW-1:0] r_out_data;
    logic          out_free;

    mrst_pkg::t_cmd  cmd;
    mrst_pkg::t_stat stat;
    logic [VW-1:0]   sum;

    // A count of zero acts as one leaf; anything past the tree size acts as the full tree
    assign leaves_eff = (r_leaves == '0) ? LW'(1)
                      : (r_leaves > mrst_pkg::LEAVES_MAX) ? mrst_pkg::LEAVES_MAX
                      : r_leaves;

    assign out_free = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_leaves    <= mrst_pkg::LEAVES_MAX;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_leaves <= i_cfg_wr_data;
            end
            // Load a new sum, or drop the beat once the sink takes it
            if (cmd.out_load) begin
                r_out_valid <= 1'b1;
                r_out_data  <= sum;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(mrst_pkg::MDATA_W - VW){1'b0}}, r_out_data};

    mrst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_op       (mrst_pkg::t_op'(s_axis_tuser)),
        .i_out_free (out_free),
        .i_stat     (stat),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    mrst_dpath u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_tdata  (s_axis_tdata),
        .i_leaves (leaves_eff),
        .o_stat   (stat),
        .o_sum    (sum)
    );

`ifndef SYNTHESIS
    a_out_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> out_free)
        else $error("result loaded over a beat still waiting");
`endif

endmodule

// ----- rtl/mrst_ctrl.sv -----
module mrst_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  mrst_pkg::t_op      i_op,
    input  logic               i_out_free,
    input  mrst_pkg::t_stat    i_stat,
    output logic               o_in_ready,
    output mrst_pkg::t_cmd     o_cmd
);

    typedef enum logic [8:0] {
        ST_SWEEP       = 9'b000000001,
        ST_IDLE        = 9'b000000010,
        ST_ADD_DESC    = 9'b000000100,
        ST_ADD_LEAF_WR = 9'b000001000,
        ST_ADD_SIB_RD  = 9'b000010000,
        ST_ADD_PAR_WR  = 9'b000100000,
        ST_QRY_WALK    = 9'b001000000,
        ST_QRY_SUM     = 9'b010000000,
        ST_QRY_OUT     = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_SWEEP;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_SWEEP: begin
                o_cmd.sweep = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    unique case (i_op)
                        mrst_pkg::OP_CLEAR: n_state = ST_SWEEP;
                        mrst_pkg::OP_ADD:   n_state = ST_ADD_DESC;
                        mrst_pkg::OP_QUERY: n_state = ST_QRY_WALK;
                        mrst_pkg::OP_NOP:   n_state = ST_IDLE;
                    endcase
                end
            end
            ST_ADD_DESC: begin
                if (!i_stat.leaf_ok) begin
                    n_state = ST_IDLE;
                end else if (i_stat.at_leaf) begin
                    o_cmd.leaf_rd = 1'b1;
                    n_state       = ST_ADD_LEAF_WR;
                end else begin
                    o_cmd.desc = 1'b1;
                end
            end
            ST_ADD_LEAF_WR: begin
                o_cmd.leaf_wr = 1'b1;
                n_state       = i_stat.at_root ? ST_IDLE : ST_ADD_SIB_RD;
            end
            ST_ADD_SIB_RD: begin
                o_cmd.sib_rd = 1'b1;
                n_state      = ST_ADD_PAR_WR;
            end
            ST_ADD_PAR_WR: begin
                o_cmd.par_wr = 1'b1;
                n_state      = i_stat.par_root ? ST_IDLE : ST_ADD_SIB_RD;
            end
            ST_QRY_WALK: begin
                if (i_stat.range_empty) begin
                    n_state = ST_QRY_OUT;
                end else begin
                    o_cmd.qry_step = 1'b1;
                    if (i_stat.walk_last) begin
                        n_state = ST_QRY_SUM;
                    end
                end
            end
            ST_QRY_SUM: begin
                n_state = ST_QRY_OUT;
            end
            ST_QRY_OUT: begin
                if (i_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/mrst_dpath.sv -----
module mrst_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mrst_pkg::t_cmd                i_cmd,
    input  logic [mrst_pkg::TDATA_W-1:0]  i_tdata,
    input  logic [mrst_pkg::LEAF_W-1:0]   i_leaves,
    output mrst_pkg::t_stat               o_stat,
    output logic [mrst_pkg::VAL_W-1:0]    o_sum
);

    localparam int LW = mrst_pkg::LEAF_W;
    localparam int VW = mrst_pkg::VAL_W;
    localparam int AW = mrst_pkg::NODE_AW;

    // Node store
    logic [VW-1:0] mem [mrst_pkg::NODES];
    logic [VW-1:0] r_rdata;

    // Latched item
    logic [LW-1:0] r_leaf;
    logic [VW-1:0] r_val;
    logic [LW-1:0] r_first;
    logic [LW-1:0] r_last;

    // Walker
    logic [AW-1:0]              r_node;
    logic [LW-1:0]              r_lo;
    logic [LW-1:0]              r_hi;
    logic [mrst_pkg::SP_W-1:0]  r_sp;
    mrst_pkg::t_frame           r_stack [mrst_pkg::STACK_DEPTH];

    logic [VW-1:0]  r_acc;
    logic           r_acc_pend;
    logic [VW-1:0]  r_run;
    logic [AW-1:0]  r_sweep_cnt;

    logic [LW-1:0]              in_leaf;
    logic [VW-1:0]              in_val;
    logic [VW-1:0]              in_val_red;
    logic [LW:0]                mid_sum;
    logic [LW-1:0]              mid;
    logic [LW-1:0]              mid_p1;
    logic [AW-1:0]              left;
    logic [AW-1:0]              right;
    logic                       disjoint;
    logic                       covered;
    logic                       stop;
    logic                       take_node;
    logic [mrst_pkg::SP_W-1:0]  sp_dec;
    mrst_pkg::t_frame           stack_top;
    logic [VW-1:0]              leaf_new;
    logic [VW-1:0]              par_new;
    logic                       rd_en;
    logic [AW-1:0]              rd_addr;
    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    logic [VW-1:0]              wr_data;

    assign in_leaf    = i_tdata[mrst_pkg::LEAF_LSB +: LW];
    assign in_val     = i_tdata[mrst_pkg::VAL_LSB +: VW];
    assign in_val_red = (in_val >= mrst_pkg::MODULUS) ? in_val - mrst_pkg::MODULUS : in_val;

    assign mid_sum   = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid       = mid_sum[LW:1];
    assign mid_p1    = mid + LW'(1);
    assign left      = {r_node[AW-2:0], 1'b0};
    assign right     = {r_node[AW-2:0], 1'b1};
    assign disjoint  = (r_last < r_lo) || (r_hi < r_first);
    assign covered   = (r_first <= r_lo) && (r_hi <= r_last);
    assign stop      = disjoint || covered;
    assign take_node = covered && !disjoint;
    assign sp_dec    = r_sp - mrst_pkg::SP_W'(1);
    assign stack_top = r_stack[sp_dec[mrst_pkg::SP_IW-1:0]];

    assign leaf_new = mrst_pkg::mod_add(r_rdata, r_val);
    assign par_new  = mrst_pkg::mod_add(r_run, r_rdata);

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_node;
        if (i_cmd.leaf_rd) begin
            rd_en = 1'b1;
        end else if (i_cmd.sib_rd) begin
            rd_en   = 1'b1;
            rd_addr = r_node ^ AW'(1);
        end else if (i_cmd.qry_step && take_node) begin
            rd_en = 1'b1;
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_sweep_cnt;
        wr_data = '0;
        priority if (i_cmd.sweep) begin
            wr_en = 1'b1;
        end else if (i_cmd.leaf_wr) begin
            wr_en   = 1'b1;
            wr_addr = r_node;
            wr_data = leaf_new;
        end else if (i_cmd.par_wr) begin
            wr_en   = 1'b1;
            wr_addr = {1'b0, r_node[AW-1:1]};
            wr_data = par_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp        <= '0;
            r_acc       <= '0;
            r_acc_pend  <= 1'b0;
            r_sweep_cnt <= '0;
        end else begin
            r_sweep_cnt <= i_cmd.sweep ? r_sweep_cnt + AW'(1) : '0;
            r_acc_pend  <= i_cmd.qry_step && take_node;

            if (i_cmd.load) begin
                r_leaf  <= in_leaf;
                r_val   <= in_val_red;
                r_first <= i_tdata[mrst_pkg::LOW_LSB +: LW];
                r_last  <= i_tdata[mrst_pkg::HIGH_LSB +: LW];
                r_node  <= AW'(1);
                r_lo    <= LW'(1);
                r_hi    <= i_leaves;
                r_sp    <= '0;
                r_acc   <= '0;
            end else if (r_acc_pend) begin
                r_acc <= mrst_pkg::mod_add(r_acc, r_rdata);
            end

            if (i_cmd.desc) begin
                if (r_leaf <= mid) begin
                    r_node <= left;
                    r_hi   <= mid;
                end else begin
                    r_node <= right;
                    r_lo   <= mid_p1;
                end
            end

            if (i_cmd.leaf_wr) begin
                r_run <= leaf_new;
            end

            if (i_cmd.par_wr) begin
                r_run  <= par_new;
                r_node <= {1'b0, r_node[AW-1:1]};
            end

            // Walk: drop a finished node and pop, or push the right half and go left
            if (i_cmd.qry_step) begin
                if (stop) begin
                    if (r_sp != '0) begin
                        r_node <= stack_top.node;
                        r_lo   <= stack_top.lo;
                        r_hi   <= stack_top.hi;
                        r_sp   <= sp_dec;
                    end
                end else begin
                    r_stack[r_sp[mrst_pkg::SP_IW-1:0]] <= '{node: right, lo: mid_p1, hi: r_hi};
                    r_sp   <= r_sp + mrst_pkg::SP_W'(1);
                    r_node <= left;
                    r_hi   <= mid;
                end
            end
        end
    end

    assign o_stat.sweep_last  = (r_sweep_cnt == AW'(mrst_pkg::NODES - 1));
    assign o_stat.leaf_ok     = (r_leaf != '0) && (r_leaf <= i_leaves);
    assign o_stat.at_leaf     = (r_lo == r_hi);
    assign o_stat.at_root     = (r_node == AW'(1));
    assign o_stat.par_root    = (r_node[AW-1:1] == (AW-1)'(1));
    assign o_stat.range_empty = (r_first > r_last);
    assign o_stat.walk_last   = stop && (r_sp == '0);
    assign o_sum              = r_acc;

`ifndef SYNTHESIS
    a_wr_below_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (wr_data < mrst_pkg::MODULUS))
        else $error("node write at or above modulus");

    a_acc_below_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acc < mrst_pkg::MODULUS)
        else $error("query accumulator at or above modulus");

    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.qry_step && !stop) |-> (r_sp < mrst_pkg::SP_W'(mrst_pkg::STACK_DEPTH)))
        else $error("walk stack overflow");
`endif

endmodule
